### rtl/assert_macros.svh
// Assertion macros used by the checker file mtp_checker.sv.
// No dependencies; a file that uses them must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/mtp_pkg.sv
// Shared types and constants for the MIDI track note event parser.
// No dependencies.
package mtp_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_US_PER_TICK = 2'd1;

  localparam logic [15:0] TRACK_COUNT_RESET = 16'd1;
  localparam logic [23:0] US_PER_TICK_RESET = 24'd5208;

  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [7:0] STATUS_META = 8'hFF;

  typedef enum logic [3:0] {
    PH_ID, PH_LEN, PH_DELTA, PH_STATUS, PH_KEY, PH_VEL, PH_MTYPE, PH_MLEN, PH_SKIP
  } phase_t;

  // One classified event handed from parser to output stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic [7:0]  velocity;
    logic [27:0] delta;
  } event_t;

endpackage

### rtl/midi_track_note_event_parser.sv
// MIDI track note event parser, top level.
// Depends on mtp_pkg, mtp_front, mtp_queue and mtp_back.
//
// Feed the bytes of a Standard MIDI File that follow its 14-byte header, one
// byte per item on data_byte. The parser walks track_count track chunks:
// chunk ID skipped, 32-bit big-endian length loaded, then events. Each note
// on or note off yields one result item with key, velocity and delay_us =
// delta ticks * us_per_tick (low 32 bits). Meta events, other channel
// messages and F-status events are skipped. A running-status byte (below
// 0x80) yields one item with event_kind = error and zero payload, and the
// block then ignores all input until reset. After the last track, bytes are
// consumed silently. Throughput is one byte per cycle: the parser updates its
// state on each accepted byte, and in_ready drops only when the event
// queue (QUEUE_DEPTH records) is full because the result side is stalled.
// A note result is written into the queue on the edge that takes its velocity
// byte; the record is then popped through the 28x24 multiplier into the output
// register once it is at the queue head and the output side is idle or ready.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect
// at once; writing track_count also reloads the remaining-track counter.
module midi_track_note_event_parser #(
  parameter int QUEUE_DEPTH = mtp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // byte input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_kind,
  output logic [7:0]                      note_key,
  output logic [7:0]                      note_velocity,
  output logic [31:0]                     delay_us,
  // configuration
  input  logic                            cfg_write,
  input  logic [mtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic            accept;
  logic            push;
  mtp_pkg::event_t push_data;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  mtp_pkg::event_t q_head;

  // Front stalls only on a full queue; every byte is otherwise taken.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  mtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_tracks (cfg_data[15:0]),
    .push       (push),
    .push_data  (push_data)
  );

  mtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  mtp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_tick      (cfg_data[23:0]),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .note_key      (note_key),
    .note_velocity (note_velocity),
    .delay_us      (delay_us)
  );

endmodule

### rtl/mtp_front.sv
// Byte parser: chunk headers, delta VLQ, status decode, skipping.
// Depends on mtp_pkg; emits event_t records for the queue.
module mtp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     data_byte,
  input  logic                           cfg_write,
  input  logic [mtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_tracks,
  output logic                           push,
  output mtp_pkg::event_t                push_data
);

  mtp_pkg::phase_t phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [27:0] vlq, vlq_next;
  logic [27:0] delta, delta_next;
  logic        msg_kind, msg_kind_next;
  logic [7:0]  held_key, held_key_next;
  logic [27:0] skip_left, skip_left_next;
  logic [15:0] tracks_left, tracks_left_next;
  logic        error_latched, error_latched_next;

  logic [2:0]  hdr_inc;
  logic [31:0] chunk_dec;
  logic [31:0] len_shift;
  logic [27:0] vlq_in;
  logic [27:0] skip_dec;
  logic        boundary;
  logic [31:0] boundary_chunk;

  always_comb begin
    hdr_inc   = hdr_count + 3'd1;
    chunk_dec = (chunk_left != 32'd0) ? chunk_left - 32'd1 : 32'd0;
    len_shift = {chunk_left[23:0], data_byte};
    vlq_in    = {vlq[20:0], data_byte[6:0]};
    skip_dec  = (skip_left != 28'd0) ? skip_left - 28'd1 : 28'd0;

    phase_next         = phase;
    hdr_count_next     = hdr_count;
    chunk_left_next    = chunk_left;
    vlq_next           = vlq;
    delta_next         = delta;
    msg_kind_next      = msg_kind;
    held_key_next      = held_key;
    skip_left_next     = skip_left;
    tracks_left_next   = tracks_left;
    error_latched_next = error_latched;
    boundary           = 1'b0;
    boundary_chunk     = chunk_dec;
    push               = 1'b0;
    push_data          = '0;

    if (accept && !error_latched) begin
      if (phase != mtp_pkg::PH_ID && phase != mtp_pkg::PH_LEN) begin
        chunk_left_next = chunk_dec;
      end
      case (phase)
        mtp_pkg::PH_ID: begin
          if (tracks_left != 16'd0) begin
            hdr_count_next = hdr_inc;
            if (hdr_inc >= 3'd4) begin
              phase_next      = mtp_pkg::PH_LEN;
              hdr_count_next  = 3'd0;
              chunk_left_next = 32'd0;
            end
          end
        end
        mtp_pkg::PH_LEN: begin
          chunk_left_next = len_shift;
          hdr_count_next  = hdr_inc;
          if (hdr_inc >= 3'd4) begin
            hdr_count_next = 3'd0;
            boundary       = 1'b1;
            boundary_chunk = len_shift;
          end
        end
        mtp_pkg::PH_DELTA: begin
          vlq_next = vlq_in;
          if (!data_byte[7]) begin
            delta_next = vlq_in;
            vlq_next   = 28'd0;
            phase_next = mtp_pkg::PH_STATUS;
          end
        end
        mtp_pkg::PH_STATUS: begin
          if (!data_byte[7]) begin
            error_latched_next = 1'b1;
            push               = 1'b1;
            push_data.kind     = mtp_pkg::KIND_ERROR;
          end else if (data_byte == mtp_pkg::STATUS_META) begin
            phase_next = mtp_pkg::PH_MTYPE;
          end else begin
            case (data_byte[7:4])
              4'h8: begin
                msg_kind_next = 1'b0;
                phase_next    = mtp_pkg::PH_KEY;
              end
              4'h9: begin
                msg_kind_next = 1'b1;
                phase_next    = mtp_pkg::PH_KEY;
              end
              4'hC, 4'hD: begin
                skip_left_next = 28'd1;
                phase_next     = mtp_pkg::PH_SKIP;
              end
              default: begin
                skip_left_next = 28'd2;
                phase_next     = mtp_pkg::PH_SKIP;
              end
            endcase
          end
        end
        mtp_pkg::PH_KEY: begin
          held_key_next = data_byte;
          phase_next    = mtp_pkg::PH_VEL;
        end
        mtp_pkg::PH_VEL: begin
          push               = 1'b1;
          push_data.kind     = msg_kind ? mtp_pkg::KIND_NOTE_ON : mtp_pkg::KIND_NOTE_OFF;
          push_data.key      = held_key;
          push_data.velocity = data_byte;
          push_data.delta    = delta;
          boundary           = 1'b1;
        end
        mtp_pkg::PH_MTYPE: begin
          vlq_next   = 28'd0;
          phase_next = mtp_pkg::PH_MLEN;
        end
        mtp_pkg::PH_MLEN: begin
          vlq_next = vlq_in;
          if (!data_byte[7]) begin
            skip_left_next = vlq_in;
            vlq_next       = 28'd0;
            if (vlq_in == 28'd0) begin
              boundary = 1'b1;
            end else begin
              phase_next = mtp_pkg::PH_SKIP;
            end
          end
        end
        mtp_pkg::PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 28'd0) begin
            boundary = 1'b1;
          end
        end
        default: begin
          phase_next     = mtp_pkg::PH_ID;
          hdr_count_next = 3'd0;
        end
      endcase

      // Event boundary: next chunk header once the chunk is used up.
      if (boundary) begin
        if (boundary_chunk == 32'd0) begin
          phase_next     = mtp_pkg::PH_ID;
          hdr_count_next = 3'd0;
          if (tracks_left != 16'd0) begin
            tracks_left_next = tracks_left - 16'd1;
          end
        end else begin
          phase_next = mtp_pkg::PH_DELTA;
          vlq_next   = 28'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mtp_pkg::PH_ID;
      hdr_count     <= 3'd0;
      tracks_left   <= mtp_pkg::TRACK_COUNT_RESET;
      error_latched <= 1'b0;
    end else begin
      phase         <= phase_next;
      hdr_count     <= hdr_count_next;
      error_latched <= error_latched_next;
      if (cfg_write && cfg_index == mtp_pkg::REG_TRACK_COUNT) begin
        tracks_left <= cfg_tracks;
      end else begin
        tracks_left <= tracks_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    chunk_left <= chunk_left_next;
    vlq        <= vlq_next;
    delta      <= delta_next;
    msg_kind   <= msg_kind_next;
    held_key   <= held_key_next;
    skip_left  <= skip_left_next;
  end

endmodule

### rtl/mtp_queue.sv
// Small FIFO of event records between parser and output stage.
// Depends on mtp_pkg for event_t.
module mtp_queue #(
  parameter int DEPTH = mtp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mtp_pkg::event_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output mtp_pkg::event_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  mtp_pkg::event_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/mtp_back.sv
// Output stage: delay multiply and the registered result item.
// Depends on mtp_pkg; holds the us_per_tick register.
module mtp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                     cfg_tick,
  input  logic                            q_valid,
  input  mtp_pkg::event_t                 q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_kind,
  output logic [7:0]                      note_key,
  output logic [7:0]                      note_velocity,
  output logic [31:0]                     delay_us
);

  logic [23:0] us_per_tick;
  logic [51:0] product;

  assign q_pop   = q_valid && (!out_valid || out_ready);
  assign product = q_head.delta * us_per_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      us_per_tick <= mtp_pkg::US_PER_TICK_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == mtp_pkg::REG_US_PER_TICK) begin
        us_per_tick <= cfg_tick;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_kind    <= q_head.kind;
      note_key      <= q_head.key;
      note_velocity <= q_head.velocity;
      delay_us      <= product[31:0];
    end
  end

endmodule

### rtl/mtp_checker.sv
// Port-level checks for the MIDI track note event parser, bound to the top.
// Depends on mtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [7:0]  note_key,
  input logic [7:0]  note_velocity,
  input logic [31:0] delay_us
);

  // A stalled result item holds.
  `CHK_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(event_kind) && $stable(note_key) && $stable(delay_us))

  // Error items carry an all-zero payload.
  `CHK_NOW(a_err_zero, out_valid && event_kind == mtp_pkg::KIND_ERROR,
    note_key == 8'd0 && note_velocity == 8'd0 && delay_us == 32'd0)

  // Only the three defined kinds leave the block.
  `CHK_NOW(a_kind_legal, out_valid,
    event_kind == mtp_pkg::KIND_NOTE_OFF || event_kind == mtp_pkg::KIND_NOTE_ON ||
    event_kind == mtp_pkg::KIND_ERROR)

  // The error item is the last one until reset.
  `CHK_NEXT(a_err_last, out_valid && out_ready && event_kind == mtp_pkg::KIND_ERROR,
    !out_valid)

endmodule

bind midi_track_note_event_parser mtp_checker u_mtp_checker (.*);

### verif/midi_track_note_event_parser_test.sv
// Self-checking testbench for midi_track_note_event_parser: track-chunk bytes in, note items out.
// A directed table runs with phase-aware random byte streams in its middle; items are checked by a predictor or table.
// Depends on mtp_pkg and the parser RTL only.
module midi_track_note_event_parser_test;

  // Channel status nibbles (upper half of a status byte)
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  // Register slots that decode to nothing
  localparam logic [mtp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [mtp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;

  localparam int RANDOM_ITEMS  = 810;
  localparam int SETTLE_CYCLES = 4;     // result passes the queue and the output register after its velocity byte
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int PLAN_ROWS     = 41;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic [7:0]  velocity;
    logic [31:0] delay;
  } note_result_t;

  typedef enum logic [1:0] {DO_BYTE, DO_REG, DO_RANDOM} step_kind_t;

  typedef struct packed {
    step_kind_t                         what;
    logic [7:0]                         data;
    logic [mtp_pkg::CFG_INDEX_W-1:0]    reg_idx;
    logic [mtp_pkg::CFG_DATA_W-1:0]     reg_val;
    logic                               typed;   // result written into the row itself
    note_result_t                       want;
  } plan_row_t;

  // ---- table row builders ----
  function automatic plan_row_t feed(input logic [7:0] b);
    plan_row_t row;
    row = '0;
    row.what = DO_BYTE;
    row.data = b;
    return row;
  endfunction

  function automatic plan_row_t feed_check(input logic [7:0] b, input logic [1:0] kind,
                                           input logic [7:0] key, input logic [7:0] vel,
                                           input logic [31:0] delay);
    plan_row_t row;
    row = feed(b);
    row.typed = 1'b1;
    row.want = '{kind: kind, key: key, velocity: vel, delay: delay};
    return row;
  endfunction

  function automatic plan_row_t set_reg(input logic [mtp_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [mtp_pkg::CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.what = DO_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t random_part();
    plan_row_t row;
    row = '0;
    row.what = DO_RANDOM;
    return row;
  endfunction

  // Directed stimulus. Random traffic sits in the middle; the format error goes
  // last because it halts the parser until a reset that never comes.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset defaults: one track, 5208 us per tick
    feed(8'h4D), feed(8'h54), feed(8'h72), feed(8'h6B),
    feed(8'h00), feed(8'h00), feed(8'h00), feed(8'h04),
    feed(8'h01), feed({ST_NOTE_ON, 4'h0}), feed(8'h3C),
    feed_check(8'h40, mtp_pkg::KIND_NOTE_ON, 8'h3C, 8'h40, 32'd5208),
    // track budget used up: dropped silently
    feed(8'h55),
    // dead index first, then both registers at their top values
    set_reg(REG_UNUSED_HI, 24'hFFFFFF),
    set_reg(mtp_pkg::REG_TRACK_COUNT, 24'h00FFFF),
    set_reg(mtp_pkg::REG_US_PER_TICK, 24'hFFFFFF),
    // chunk of 11 bytes: longest 4-byte delta, note off with all-ones payload
    feed(8'h00), feed(8'h00), feed(8'h00), feed(8'h00),
    feed(8'h00), feed(8'h00), feed(8'h00), feed(8'h0B),
    feed(8'hFF), feed(8'hFF), feed(8'hFF), feed(8'h7F),
    feed({ST_NOTE_OFF, 4'hF}), feed(8'hFF),
    feed_check(8'hFF, mtp_pkg::KIND_NOTE_OFF, 8'hFF, 8'hFF, 32'hEF00_0001),
    // zero-length meta closes the chunk exactly
    feed(8'h00), feed(mtp_pkg::STATUS_META), feed(8'h2F), feed(8'h00),
    random_part(),
    // data byte where a status belongs
    feed(8'h05),
    feed_check(8'h7F, mtp_pkg::KIND_ERROR, 8'h00, 8'h00, 32'd0),
    // everything after the error is dropped
    feed({ST_NOTE_ON, 4'h0}), feed(8'h3C), feed(8'h40)
  };

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      data_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      event_kind;
  logic [7:0]                      note_key;
  logic [7:0]                      note_velocity;
  logic [31:0]                     delay_us;
  logic                            cfg_write;
  logic [mtp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mtp_pkg::CFG_DATA_W-1:0]  cfg_data;

  midi_track_note_event_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .note_key      (note_key),
    .note_velocity (note_velocity),
    .delay_us      (delay_us),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // ---- parser shadow state ----
  mtp_pkg::phase_t phase_now;
  logic [2:0]   id_len_count;      // bytes seen of chunk id / length
  logic [31:0]  chunk_remaining;
  logic [27:0]  vlq_sum;
  logic [27:0]  event_ticks;
  logic         note_is_on;
  logic [7:0]   key_hold;
  logic [27:0]  bytes_to_skip;
  logic [15:0]  tracks_remaining;
  logic         parser_halted;
  logic [23:0]  cfg_tick_us;

  note_result_t pending_notes [$];  // predicted items not yet seen at the output
  int           fail_count;
  bit           gap_free;          // sender runs back to back in this phase

  function void shadow_reset();
    phase_now        = mtp_pkg::PH_ID;
    id_len_count     = '0;
    chunk_remaining  = '0;
    vlq_sum          = '0;
    event_ticks      = '0;
    note_is_on       = 1'b0;
    key_hold         = '0;
    bytes_to_skip    = '0;
    tracks_remaining = mtp_pkg::TRACK_COUNT_RESET;
    parser_halted    = 1'b0;
    cfg_tick_us      = mtp_pkg::US_PER_TICK_RESET;
  endfunction

  // Event done: next chunk header if the length is used up, else the next delta.
  function void close_event();
    if (chunk_remaining == 0) begin
      phase_now = mtp_pkg::PH_ID;
      id_len_count = '0;
      if (tracks_remaining != 0) tracks_remaining--;
    end else begin
      phase_now = mtp_pkg::PH_DELTA;
      vlq_sum = '0;
    end
  endfunction

  function bit byte_ignored();
    return parser_halted || (phase_now == mtp_pkg::PH_ID && tracks_remaining == 0);
  endfunction

  // Advance the shadow parser by one accepted byte; returns 1 when an item is due.
  function bit predict_byte(input logic [7:0] b, output note_result_t r);
    logic [51:0] product;
    r = '0;
    if (byte_ignored()) return 1'b0;
    if (phase_now == mtp_pkg::PH_ID) begin
      id_len_count++;
      if (id_len_count >= 4) begin
        phase_now = mtp_pkg::PH_LEN;
        id_len_count = '0;
        chunk_remaining = '0;
      end
      return 1'b0;
    end
    if (phase_now == mtp_pkg::PH_LEN) begin
      chunk_remaining = {chunk_remaining[23:0], b};
      id_len_count++;
      if (id_len_count >= 4) begin
        id_len_count = '0;
        close_event();
      end
      return 1'b0;
    end
    // event bytes count against the chunk, saturating at zero
    if (chunk_remaining != 0) chunk_remaining--;
    case (phase_now)
      mtp_pkg::PH_DELTA: begin
        vlq_sum = {vlq_sum[20:0], b[6:0]};
        if (!b[7]) begin
          event_ticks = vlq_sum;
          vlq_sum = '0;
          phase_now = mtp_pkg::PH_STATUS;
        end
      end
      mtp_pkg::PH_STATUS: begin
        if (!b[7]) begin
          parser_halted = 1'b1;
          r.kind = mtp_pkg::KIND_ERROR;
          return 1'b1;
        end
        if (b == mtp_pkg::STATUS_META) begin
          phase_now = mtp_pkg::PH_MTYPE;
        end else begin
          case (b[7:4])
            ST_NOTE_OFF: begin
              note_is_on = 1'b0;
              phase_now = mtp_pkg::PH_KEY;
            end
            ST_NOTE_ON: begin
              note_is_on = 1'b1;
              phase_now = mtp_pkg::PH_KEY;
            end
            ST_PROGRAM, ST_CHAN_PRESS: begin
              bytes_to_skip = 28'd1;
              phase_now = mtp_pkg::PH_SKIP;
            end
            default: begin
              bytes_to_skip = 28'd2;
              phase_now = mtp_pkg::PH_SKIP;
            end
          endcase
        end
      end
      mtp_pkg::PH_KEY: begin
        key_hold = b;
        phase_now = mtp_pkg::PH_VEL;
      end
      mtp_pkg::PH_VEL: begin
        product = {24'd0, event_ticks} * {28'd0, cfg_tick_us};
        r.kind = note_is_on ? mtp_pkg::KIND_NOTE_ON : mtp_pkg::KIND_NOTE_OFF;
        r.key = key_hold;
        r.velocity = b;
        r.delay = product[31:0];
        close_event();
        return 1'b1;
      end
      mtp_pkg::PH_MTYPE: begin
        vlq_sum = '0;
        phase_now = mtp_pkg::PH_MLEN;
      end
      mtp_pkg::PH_MLEN: begin
        vlq_sum = {vlq_sum[20:0], b[6:0]};
        if (!b[7]) begin
          bytes_to_skip = vlq_sum;
          vlq_sum = '0;
          if (bytes_to_skip == 0) close_event();
          else phase_now = mtp_pkg::PH_SKIP;
        end
      end
      mtp_pkg::PH_SKIP: begin
        if (bytes_to_skip != 0) bytes_to_skip--;
        if (bytes_to_skip == 0) close_event();
      end
      default: begin
        phase_now = mtp_pkg::PH_ID;
        id_len_count = '0;
      end
    endcase
    return 1'b0;
  endfunction

  // Next random byte, shaped by where the parser is so most traffic stays
  // well formed. Status bytes never drop below 0x80 here. With steer set, the
  // chunk length is forced nonzero so events are reached.
  function automatic logic [7:0] pick_byte(input bit steer);
    int         r;
    logic [7:0] b;
    logic [3:0] nib;
    r = $urandom_range(0, 99);
    b = 8'($urandom);
    nib = 4'($urandom);
    if (r < 5 && phase_now != mtp_pkg::PH_STATUS && phase_now != mtp_pkg::PH_LEN)
      return b;  // noise
    case (phase_now)
      mtp_pkg::PH_LEN: begin
        // keep chunks short; a huge length would swallow the rest of the run
        if (id_len_count < 2) b = ($urandom_range(0, 399) == 0) ? b : 8'h00;
        else if (id_len_count == 2)
          b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 3)) : 8'h00;
        else if (r < 90) b = 8'($urandom_range(0, 48));
        if (steer && id_len_count == 3) b[0] = 1'b1;
      end
      mtp_pkg::PH_DELTA: b[7] = (r < 33);  // continuation; five or more groups now and then
      mtp_pkg::PH_STATUS: begin
        if (r < 40) b = {ST_NOTE_ON, nib};
        else if (r < 65) b = {ST_NOTE_OFF, nib};
        else if (r < 75) b = mtp_pkg::STATUS_META;
        else if (r < 84) begin
          case ($urandom_range(0, 2))
            0: b = {ST_POLY_PRESS, nib};
            1: b = {ST_CONTROL, nib};
            default: b = {ST_PITCH_BEND, nib};
          endcase
        end else if (r < 92) b = {($urandom_range(0, 1) != 0) ? ST_PROGRAM : ST_CHAN_PRESS, nib};
        else b = {ST_SYSTEM, nib};
      end
      mtp_pkg::PH_MLEN: begin
        if (r < 6) b = {7'b100_0000, 1'($urandom)};
        else b = 8'($urandom_range(0, 6));
      end
      default: ;  // id, key, velocity, meta type, skipped data: anything goes
    endcase
    return b;
  endfunction

  function int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_free || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---- sender side: called at a falling edge, returns at one ----
  // valid stays up on return; the next call or settle_idle decides what follows.
  task automatic send_byte(input logic [7:0] b, input logic typed, input note_result_t want);
    int           gap;
    bit           has;
    note_result_t got;
    gap = next_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = predict_byte(b, got);
    if (typed) pending_notes.push_back(want);
    else if (has) pending_notes.push_back(got);
    @(negedge clk);
  endtask

  // Hold input, wait for all predicted items, then let the pipe empty out.
  task automatic settle_idle();
    in_valid = 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mtp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mtp_pkg::CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == mtp_pkg::REG_TRACK_COUNT) tracks_remaining = val[15:0];
    else if (idx == mtp_pkg::REG_US_PER_TICK) cfg_tick_us = val;
  endtask

  // New register settings for one random phase. The first phases pin the
  // extremes (zero tick, full tick, zero tracks); later ones mostly random.
  task automatic reconfigure(input int phase_no);
    int          r;
    logic [15:0] tracks;
    logic [23:0] tick;
    r = $urandom_range(0, 9);
    tracks = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
    r = $urandom_range(0, 9);
    tick = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF :
           (r < 5) ? 24'($urandom) : 24'($urandom_range(1, 10000));
    if (phase_no == 0) tick = 24'd0;
    if (phase_no == 1) tick = 24'hFFFFFF;
    if (phase_no == 2) tracks = 16'd0;
    settle_idle();
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI, 24'($urandom));
    // upper byte of the data is junk on a track count write
    if (phase_no < 3 || $urandom_range(0, 2) != 0)
      write_reg(mtp_pkg::REG_TRACK_COUNT, {8'($urandom), tracks});
    if (phase_no < 3 || $urandom_range(0, 2) != 0)
      write_reg(mtp_pkg::REG_US_PER_TICK, tick);
  endtask

  task automatic run_random_part();
    int sent;
    int phase_no;
    int phase_len;
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      reconfigure(phase_no);
      gap_free = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 150);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (byte_ignored()) begin
          // out of tracks: a couple of dropped bytes, then a new setting
          repeat (2) send_byte(8'($urandom), 1'b0, '0);
          break;
        end
        send_byte(pick_byte(1'b0), 1'b0, '0);
        sent++;
      end
      phase_no++;
    end
    gap_free = 1'b0;
    // park at the start of an event so the error rows land on a status byte
    settle_idle();
    write_reg(mtp_pkg::REG_TRACK_COUNT, 24'd2);
    while (phase_now != mtp_pkg::PH_DELTA) send_byte(pick_byte(1'b1), 1'b0, '0);
  endtask

  // ---- main sequence ----
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    gap_free = 1'b0;
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].what)
        DO_BYTE: send_byte(PLAN[i].data, PLAN[i].typed, PLAN[i].want);
        DO_REG: begin
          settle_idle();
          write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
        end
        default: run_random_part();
      endcase
    end
    in_valid = 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    // quiet tail: anything that shows up now is unexpected
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // ---- result side: ready runs and stalls, some long, some never-stall stretches ----
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      int r;
      r = $urandom_range(0, 99);
      out_ready = 1'b1;
      if (r < 10) begin
        repeat ($urandom_range(50, 200)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 60) repeat ($urandom_range(1, 2)) @(negedge clk);
        else if (r < 92) repeat ($urandom_range(3, 8)) @(negedge clk);
        else repeat ($urandom_range(15, 40)) @(negedge clk);
      end
    end
  end

  // ---- output checker: each item against the oldest prediction ----
  always @(posedge clk) begin : check_results
    note_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_notes.size() == 0) begin
        $error("unexpected item: kind %0d key %0h velocity %0h delay %0d",
               event_kind, note_key, note_velocity, delay_us);
        fail_count++;
      end else begin
        want = pending_notes.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          fail_count++;
        end
        if (note_key !== want.key) begin
          $error("note_key: expected %0h, got %0h", want.key, note_key);
          fail_count++;
        end
        if (note_velocity !== want.velocity) begin
          $error("note_velocity: expected %0h, got %0h", want.velocity, note_velocity);
          fail_count++;
        end
        if (delay_us !== want.delay) begin
          $error("delay_us: expected %0d, got %0d", want.delay, delay_us);
          fail_count++;
        end
      end
    end
  end

  // ---- watchdog: too long without any handshake ends the run ----
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
